// ===== hdl/tbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types, register indexes and constants of the tracked box smoother.
// ----------------------------------------------------------------------------
package tbs_pkg;

   localparam int FRAC_BITS          = 16;
   localparam int HIST_DEPTH_DEFAULT = 30;
   localparam int QUOT_BITS          = 13;
   localparam int CSR_INDEX_BITS     = 4;
   localparam int CSR_DATA_BITS      = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIMEOUT   = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POS_THR   = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIZE_THR  = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POS_SMTH  = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIZE_SMTH = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIST_LEN  = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_W   = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_H   = 4'd7;

   typedef enum logic [1:0] {
      EV_EMPTY   = 2'd0,
      EV_ENTERED = 2'd1,
      EV_UPDATED = 2'd2,
      EV_LEFT    = 2'd3
   } ev_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SMUL, ST_SADD, ST_PUSH, ST_WALK, ST_WEND,
      ST_MULX, ST_DIVX, ST_MULY, ST_DIVY, ST_SZ1, ST_SZ2, ST_DONE
   } st_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic       done;
      logic [QUOT_BITS-1:0] quot;
   } div_stat_type;

   function automatic logic [11:0] sat12(input logic [QUOT_BITS-1:0] v);
      sat12 = (v > QUOT_BITS'(4095)) ? 12'hFFF : v[11:0];
   endfunction

endpackage

// ===== hdl/tbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/tbs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_div
// Restoring divider, one quotient bit per cycle, QUOT_BITS bits of quotient.
// ----------------------------------------------------------------------------
module tbs_div
   import tbs_pkg::*;
#(
   parameter int NW = 40
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output div_stat_type  stat
);

   localparam int CW = $clog2(QUOT_BITS);

   logic [NW-1:0]        rem_ff, rem_in;
   logic [NW-1:0]        dsh_ff, dsh_in;
   logic [QUOT_BITS-1:0] q_ff, q_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // one subtract-and-compare step per cycle
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = divisor << (QUOT_BITS - 1);
         q_in    = '0;
         cnt_in  = CW'(QUOT_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = q_ff;

endmodule

// ===== hdl/tracked_box_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracked_box_smoother
// Presence tracking, deadband and exponential smoothing of one box per frame,
// with a weighted centroid over a center history kept in RAM.
// ----------------------------------------------------------------------------
//  channel  direction  ports                    content
//  req      in         req_tvalid/tready/tdata  tdata: box; tuser: found
//  rsp      out        rsp_tvalid/tready/tdata  tdata: id, age, box, centroid
//  csr      in         csr_valid/ready          csr_index, csr_data
//
//  An item without a box goes from accept straight to ST_DONE, where its
//  result is loaded into the output register. An item with a box passes
//  through the shared smoothing multiplier, the RAM walk over the history
//  length, two divider runs with an operand state before each, the size
//  term and the load of the result. The next accept can follow in the cycle
//  after the result is loaded. One item is worked on at a time.
//  Reset is synchronous; the history needs no clearing pass (a fill count
//  masks entries never written). A stalled rsp holds the next result only.
// ----------------------------------------------------------------------------
module tracked_box_smoother
   import tbs_pkg::*;
#(
   parameter int HISTORY_DEPTH = HIST_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,   // box_left, box_top, box_width, box_height
   input  logic                      req_tuser,   // found
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [135:0]              rsp_tdata,   // person_id, person_age, smooth_left,
                                                  // smooth_top, smooth_width, smooth_height,
                                                  // centroid_x, centroid_y, centroid_size, pad
   output logic [1:0]                rsp_tuser,   // event_res
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int LW = $clog2(HISTORY_DEPTH + 1);
   localparam int TMAX = HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2;
   localparam int TW = $clog2(TMAX + 1);
   localparam int PW = LW + FRAC_BITS;
   localparam int SW = TW + FRAC_BITS;
   localparam int NW = SW + 12 + 1;

   // configuration registers
   logic [5:0]  cfg_timeout_ff;
   logic [15:0] cfg_pos_thr_ff, cfg_size_thr_ff, cfg_pos_smth_ff, cfg_size_smth_ff;
   logic [4:0]  cfg_hist_len_ff;
   logic [11:0] cfg_frame_w_ff, cfg_frame_h_ff;

   // tracking state
   st_type      state_ff, state_in;
   logic        was_found_ff;
   logic [15:0] id_ff, age_ff;
   logic [7:0]  fsu_ff;
   ev_type      ev_ff;
   logic [15:0] box_ff [4];
   logic [15:0] sb_ff [4];
   logic [1:0]  k_ff;
   logic signed [34:0] prod_ff;
   logic        take_ff;
   logic [AW-1:0] head_ff, rd_ptr_ff;
   logic [LW-1:0] cnt_ff, len_ff, idx_ff;
   logic [TW-1:0] tri_ff;
   logic        pv_ff, pok_ff;
   logic [PW-1:0] px_ff, py_ff;
   logic [SW-1:0] sx_ff, sy_ff;
   logic [27:0] szacc_ff;
   logic [11:0] hcx_ff, hcy_ff, hcs_ff;
   logic        rsp_tvalid_ff;
   logic [135:0] rsp_tdata_ff;
   logic [1:0]  rsp_tuser_ff;

   // control
   logic        req_acc, ram_we, div_start, out_load;
   logic [AW-1:0] head_nx;
   logic [31:0] ram_wdata, ram_rdata;
   logic [NW-1:0] div_num, div_den;
   div_stat_type div_st;

   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_timeout_ff   <= '0;
         cfg_pos_thr_ff   <= 16'd13107;
         cfg_size_thr_ff  <= 16'd13107;
         cfg_pos_smth_ff  <= 16'd13107;
         cfg_size_smth_ff <= 16'd13107;
         cfg_hist_len_ff  <= 5'd10;
         cfg_frame_w_ff   <= 12'd640;
         cfg_frame_h_ff   <= 12'd480;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TIMEOUT:   cfg_timeout_ff   <= csr_data[5:0];
            REG_POS_THR:   cfg_pos_thr_ff   <= csr_data;
            REG_SIZE_THR:  cfg_size_thr_ff  <= csr_data;
            REG_POS_SMTH:  cfg_pos_smth_ff  <= csr_data;
            REG_SIZE_SMTH: cfg_size_smth_ff <= csr_data;
            REG_HIST_LEN:  cfg_hist_len_ff  <= csr_data[4:0];
            REG_FRAME_W:   cfg_frame_w_ff   <= csr_data[11:0];
            REG_FRAME_H:   cfg_frame_h_ff   <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc) state_in = req_tuser ? ST_SMUL : ST_DONE;
         ST_SMUL: state_in = ST_SADD;
         ST_SADD: state_in = (k_ff == 2'd3) ? ST_PUSH : ST_SMUL;
         ST_PUSH: state_in = ST_WALK;
         ST_WALK: if (idx_ff == len_ff - 1'b1) state_in = ST_WEND;
         ST_WEND: state_in = ST_MULX;
         ST_MULX: state_in = ST_DIVX;
         ST_DIVX: if (div_st.done) state_in = ST_MULY;
         ST_MULY: state_in = ST_DIVY;
         ST_DIVY: if (div_st.done) state_in = ST_SZ1;
         ST_SZ1:  state_in = ST_SZ2;
         ST_SZ2:  state_in = ST_DONE;
         ST_DONE: if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff) inside
         ST_IDLE: req_tready = 1'b1;
         ST_PUSH: ram_we     = 1'b1;
         ST_MULX, ST_MULY: div_start = 1'b1;
         ST_DONE: out_load   = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   // event decision on accept
   logic [7:0]  d_cnt;
   ev_type      ev_new;
   always_comb begin
      d_cnt = (fsu_ff == 8'hFF) ? 8'hFF : fsu_ff + 8'd1;
      if (req_tuser && !was_found_ff)     ev_new = EV_ENTERED;
      else if (req_tuser)                 ev_new = EV_UPDATED;
      else if (was_found_ff)              ev_new = (cfg_timeout_ff == '0) ? EV_LEFT : EV_UPDATED;
      else if (d_cnt < {2'b0, cfg_timeout_ff})  ev_new = EV_UPDATED;
      else if (d_cnt == {2'b0, cfg_timeout_ff}) ev_new = EV_LEFT;
      else                                ev_new = EV_EMPTY;
   end

   // smoothing of coordinate k: one shared multiplier
   logic [15:0] s_old, s_new, s_thr, s_w, s_diff, s_res;
   logic signed [17:0] s_dlt;
   logic signed [35:0] s_acc;
   always_comb begin
      s_old  = sb_ff[k_ff];
      s_new  = box_ff[k_ff];
      s_thr  = k_ff[1] ? cfg_size_thr_ff : cfg_pos_thr_ff;
      s_w    = k_ff[1] ? cfg_size_smth_ff : cfg_pos_smth_ff;
      s_diff = (s_old > s_new) ? s_old - s_new : s_new - s_old;
      s_dlt  = $signed({2'b0, s_old}) - $signed({2'b0, s_new});
      s_acc  = $signed({4'b0, s_new, 16'b0}) + 36'(prod_ff)
             + $signed(36'(1) <<< (FRAC_BITS - 1));
      s_res  = take_ff ? s_acc[FRAC_BITS +: 16] : s_old;
   end

   // new center and history addressing
   logic [16:0] cx_sum, cy_sum;
   logic [15:0] cx_new, cy_new;
   logic [LW-1:0] len_eff;
   always_comb begin
      cx_sum  = {1'b0, sb_ff[0]} + {2'b0, sb_ff[2][15:1]};
      cy_sum  = {1'b0, sb_ff[1]} + {2'b0, sb_ff[3][15:1]};
      cx_new  = cx_sum[16] ? 16'hFFFF : cx_sum[15:0];
      cy_new  = cy_sum[16] ? 16'hFFFF : cy_sum[15:0];
      ram_wdata = {cy_new, cx_new};
      head_nx = (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      if (cfg_hist_len_ff == '0)
         len_eff = LW'(1);
      else if (7'(cfg_hist_len_ff) > 7'(HISTORY_DEPTH))
         len_eff = LW'(HISTORY_DEPTH);
      else
         len_eff = LW'(cfg_hist_len_ff);
   end

   tbs_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head_nx),
      .wr_data (ram_wdata),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // weighted sum via prefix sums: sum (L-i) c_i = sum of running totals
   logic [15:0] wx, wy;
   logic [PW-1:0] px_nx, py_nx;
   always_comb begin
      wx    = pok_ff ? ram_rdata[15:0]  : 16'd0;
      wy    = pok_ff ? ram_rdata[31:16] : 16'd0;
      px_nx = px_ff + PW'(wx);
      py_nx = py_ff + PW'(wy);
   end

   // divider operands: round(S * pixels / (T << FRAC_BITS))
   always_comb begin
      if (state_ff == ST_MULY)
         div_num = NW'(sy_ff) * NW'(cfg_frame_h_ff);
      else
         div_num = NW'(sx_ff) * NW'(cfg_frame_w_ff);
      div_num = div_num + (NW'(tri_ff) << (FRAC_BITS - 1));
      div_den = NW'(tri_ff) << FRAC_BITS;
   end

   tbs_div #(.NW(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .stat     (div_st)
   );

   // size term
   logic [29:0] sz_tot;
   logic [12:0] sz_q;
   always_comb begin
      sz_tot = 30'(szacc_ff) + 30'(sb_ff[2]) * 30'(cfg_frame_w_ff) + (30'(1) << FRAC_BITS);
      sz_q   = sz_tot[FRAC_BITS+1 +: 13];
   end

   // state registers and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         was_found_ff  <= 1'b0;
         id_ff         <= '0;
         age_ff        <= '0;
         fsu_ff        <= 8'hFF;
         head_ff       <= '0;
         cnt_ff        <= '0;
         pv_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         hcx_ff        <= 12'd320;
         hcy_ff        <= 12'd240;
         hcs_ff        <= '0;
         for (int j = 0; j < 4; j++) sb_ff[j] <= '0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= (state_ff == ST_WALK);

         // hold event, advance presence state
         if (req_acc) begin
            ev_ff        <= ev_new;
            was_found_ff <= req_tuser;
            for (int j = 0; j < 4; j++) box_ff[j] <= req_tdata[16*j +: 16];
            k_ff         <= '0;
            if (req_tuser && !was_found_ff) begin
               id_ff  <= id_ff + 16'd1;
               age_ff <= '0;
               fsu_ff <= d_cnt;
            end else if (req_tuser) begin
               if (age_ff != 16'hFFFF) age_ff <= age_ff + 16'd1;
               fsu_ff <= '0;
            end else begin
               fsu_ff <= d_cnt;
            end
         end

         if (state_ff == ST_SMUL) begin
            prod_ff <= $signed({1'b0, s_w}) * s_dlt;
            take_ff <= s_diff > s_thr;
         end
         if (state_ff == ST_SADD) begin
            sb_ff[k_ff] <= s_res;
            k_ff        <= k_ff + 2'd1;
         end

         // push newest center, start walk from it
         if (state_ff == ST_PUSH) begin
            head_ff   <= head_nx;
            rd_ptr_ff <= head_nx;
            if (cnt_ff != LW'(HISTORY_DEPTH)) cnt_ff <= cnt_ff + 1'b1;
            len_ff    <= len_eff;
            tri_ff    <= TW'((2*LW)'(len_eff) * (2*LW)'(len_eff + 1'b1) >> 1);
            idx_ff    <= '0;
            px_ff <= '0; py_ff <= '0; sx_ff <= '0; sy_ff <= '0;
         end
         if (state_ff == ST_WALK) begin
            rd_ptr_ff <= (rd_ptr_ff == '0) ? AW'(HISTORY_DEPTH - 1) : rd_ptr_ff - 1'b1;
            pok_ff    <= idx_ff < cnt_ff;
            idx_ff    <= idx_ff + 1'b1;
         end
         if (pv_ff) begin
            px_ff <= px_nx;
            py_ff <= py_nx;
            sx_ff <= sx_ff + SW'(px_nx);
            sy_ff <= sy_ff + SW'(py_nx);
         end

         if (state_ff == ST_DIVX && div_st.done) hcx_ff <= sat12(div_st.quot);
         if (state_ff == ST_DIVY && div_st.done) hcy_ff <= sat12(div_st.quot);
         if (state_ff == ST_SZ1) szacc_ff <= 28'(sb_ff[3]) * 28'(cfg_frame_h_ff);
         if (state_ff == ST_SZ2) hcs_ff   <= sat12(sz_q);

         // transfer result into output register, or drop it once taken
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tuser_ff  <= ev_ff;
            rsp_tdata_ff  <= {4'b0, hcs_ff, hcy_ff, hcx_ff,
                              sb_ff[3], sb_ff[2], sb_ff[1], sb_ff[0], age_ff, id_ff};
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== hdl/tbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks of the tracked box smoother, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker
   import tbs_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [63:0]               req_tdata,
   input logic                      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [135:0]              rsp_tdata,
   input logic [1:0]                rsp_tuser,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [CSR_DATA_BITS-1:0]  csr_data
);

   // an entry always reports a cleared age
   a_entry_age: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_ENTERED |-> rsp_tdata[31:16] == 16'd0)
      else $error("entered event with nonzero age");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while item in work");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind tracked_box_smoother tbs_checker u_tbs_checker (.*);
